// File: rtl/spd_pkg.sv
// Package for the subpicture run-length decoder: types, constants and the
// per-nibble code step used by the decode stage.
// No dependencies.
`default_nettype none

package spd_pkg;

	// Configuration register indexes
	localparam logic [1:0] REG_ROW_WIDTH   = 2'd0;
	localparam logic [1:0] REG_FIELD_LINES = 2'd1;

	// Reset values of the configuration registers
	localparam logic [12:0] ROW_WIDTH_RST   = 13'd720;
	localparam logic [11:0] FIELD_LINES_RST = 12'd240;

	// Clamps on the configured geometry
	localparam logic [12:0] MAX_WIDTH = 13'd4096;
	localparam logic [11:0] MAX_LINES = 12'd2048;

	// Code completion thresholds for one, two and three nibbles
	localparam logic [15:0] CODE_MIN1 = 16'h0004;
	localparam logic [15:0] CODE_MIN2 = 16'h0010;
	localparam logic [15:0] CODE_MIN3 = 16'h0040;

	// Result queue
	localparam int QDEPTH   = 8;
	localparam int QPTR_W   = $clog2(QDEPTH);
	localparam int QCNT_W   = $clog2(QDEPTH + 1);
	localparam int MAX_RUNS = 3;

	typedef struct packed {
		logic [11:0] column;
		logic [10:0] row;
		logic [11:0] partial;
		logic [1:0]  held;
		logic        active;
	} spd_state_t;

	typedef struct packed {
		logic [1:0]  run_color;
		logic [12:0] run_length;
		logic [11:0] run_column;
		logic [10:0] run_row;
		logic        row_end;
		logic        field_done;
		logic        data_error;
		logic        last_for_input;
	} spd_run_t;

	typedef struct packed {
		spd_state_t st;
		spd_run_t   run;
		logic       complete;
		logic       row_done;
	} spd_feed_t;

	// Results of one byte, packed from entry 0 upward
	typedef struct packed {
		logic [1:0]         count;
		spd_run_t [MAX_RUNS-1:0] run;
	} spd_push_t;

	// Take one nibble into the code; finish a run when the code is complete
	function automatic spd_feed_t spd_feed(spd_state_t st, logic [3:0] nib,
		logic [12:0] w, logic [11:0] lines);
		logic [15:0] code;
		logic [2:0]  held;
		logic        complete;
		logic [12:0] col;
		logic [12:0] rem;
		logic [13:0] len_raw;
		logic [12:0] len;
		logic [12:0] nx;
		logic [11:0] row_inc;
		logic        rend;
		logic        done;
		spd_feed_t   r;

		code     = {st.partial, nib};
		held     = {1'b0, st.held} + 3'd1;
		complete = (held == 3'd1 && code >= CODE_MIN1) ||
		           (held == 3'd2 && code >= CODE_MIN2) ||
		           (held == 3'd3 && code >= CODE_MIN3) || (held == 3'd4);
		col      = {1'b0, st.column};
		rem      = (col < w) ? (w - col) : 13'd0;
		len_raw  = code[15:2];
		// A zero-length code fills to the end of the row
		if (held == 3'd4 && code < CODE_MIN1) begin
			len = rem;
		end else if (len_raw > {1'b0, rem}) begin
			len = rem;
		end else begin
			len = len_raw[12:0];
		end
		nx       = col + len;
		rend     = (nx >= w);
		row_inc  = {1'b0, st.row} + 12'd1;
		done     = rend && (row_inc >= lines);

		r.st                 = st;
		r.complete           = complete;
		r.row_done           = complete && rend;
		r.run.run_color      = code[1:0];
		r.run.run_length     = len;
		r.run.run_column     = st.column;
		r.run.run_row        = st.row;
		r.run.row_end        = rend;
		r.run.field_done     = done;
		r.run.data_error     = 1'b0;
		r.run.last_for_input = 1'b0;

		if (!complete) begin
			r.st.partial = code[11:0];
			r.st.held    = held[1:0];
		end else begin
			r.st.partial = '0;
			r.st.held    = '0;
			if (rend) begin
				if (done) begin
					r.st.active = 1'b0;
				end else begin
					r.st.row    = row_inc[10:0];
					r.st.column = '0;
				end
			end else begin
				r.st.column = nx[11:0];
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: rtl/spd_if.sv
// Channel interfaces of the subpicture run-length decoder: coded bytes in,
// runs out, and the configuration write channel. Depends on nothing.
`default_nettype none

interface spd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       start_of_field;
	logic       last_byte;

	modport source (output valid, output data_byte, output start_of_field,
		output last_byte, input ready);
	modport sink (input valid, input data_byte, input start_of_field,
		input last_byte, output ready);
endinterface

interface spd_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  run_color;
	logic [12:0] run_length;
	logic [11:0] run_column;
	logic [10:0] run_row;
	logic        row_end;
	logic        field_done;
	logic        data_error;
	logic        last_for_input;

	modport source (output valid, output run_color, output run_length,
		output run_column, output run_row, output row_end, output field_done,
		output data_error, output last_for_input, input ready);
	modport sink (input valid, input run_color, input run_length,
		input run_column, input run_row, input row_end, input field_done,
		input data_error, input last_for_input, output ready);
endinterface

interface spd_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [12:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/subpicture_rle_decoder_top.sv
// Subpicture run-length decoder, top level. An accepted byte is held in the
// input stage; its runs are written into the result queue once the queue holds
// five runs or fewer, and the queue offers the first run after that write.
// Throughput: one byte per cycle while the queue has room; runs leave at one
// per cycle through the single output port while it is ready, so bytes that
// yield two or three runs are paced by it.
// Reset (arst_n low) empties the queue, idles the decoder, sets 720 x 240.
`default_nettype none

module subpicture_rle_decoder_top
	import spd_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	spd_in_if.sink     code,
	spd_cfg_if.sink    cfg,
	spd_out_if.source  run
);

	spd_push_t push;
	logic      space_ok;

	// Decode bytes into runs
	spd_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.code     (code),
		.cfg      (cfg),
		.space_ok (space_ok),
		.push     (push)
	);

	// Queue runs for the output channel
	spd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.space_ok (space_ok),
		.run      (run)
	);

endmodule

`default_nettype wire

// File: rtl/spd_decode.sv
// Input stage and run decoder: registers one coded byte, works both nibbles
// and the buffer-end check in one pass and pushes up to three runs.
// Depends on spd_pkg and spd_if.
`default_nettype none

module spd_decode
	import spd_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	spd_in_if.sink     code,
	spd_cfg_if.sink    cfg,
	input  wire logic  space_ok,
	output spd_push_t  push
);

	logic [7:0]  byte_s1;
	logic        sof_s1;
	logic        last_s1;
	logic        valid_s1;
	logic        advance;
	logic        accept;

	logic [12:0] row_width_q;
	logic [11:0] field_lines_q;
	spd_state_t  state_q;

	logic [12:0] w_eff;
	logic [11:0] lines_eff;
	spd_state_t  st0;
	spd_state_t  st2;
	spd_state_t  st3;
	spd_feed_t   f_hi;
	spd_feed_t   f_lo;
	logic        run_lo;
	logic        err;
	spd_run_t    err_run;
	spd_push_t   list;

	assign advance    = valid_s1 && space_ok;
	assign accept     = code.valid && code.ready;
	assign code.ready = !valid_s1 || space_ok;
	assign cfg.ready  = 1'b1;

	// Hold the accepted byte until the queue has room for its runs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= code.data_byte;
			sof_s1  <= code.start_of_field;
			last_s1 <= code.last_byte;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q   <= ROW_WIDTH_RST;
			field_lines_q <= FIELD_LINES_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_ROW_WIDTH:   row_width_q   <= cfg.data;
				REG_FIELD_LINES: field_lines_q <= cfg.data[11:0];
				default: ;
			endcase
		end
	end

	assign w_eff     = (row_width_q > MAX_WIDTH) ? MAX_WIDTH : row_width_q;
	assign lines_eff = (field_lines_q > MAX_LINES) ? MAX_LINES : field_lines_q;

	// Work both nibbles of the byte, then the buffer-end check
	always_comb begin
		st0 = state_q;
		if (sof_s1) begin
			st0        = '0;
			st0.active = 1'b1;
		end
		f_hi   = spd_feed(st0, byte_s1[7:4], w_eff, lines_eff);
		f_lo   = spd_feed(f_hi.st, byte_s1[3:0], w_eff, lines_eff);
		run_lo = st0.active && f_hi.st.active && !f_hi.row_done;
		if (!st0.active) begin
			st2 = st0;
		end else if (run_lo) begin
			st2 = f_lo.st;
		end else begin
			st2 = f_hi.st;
		end

		err                    = st0.active && last_s1 && st2.active;
		err_run                = '0;
		err_run.run_column     = st2.column;
		err_run.run_row        = st2.row;
		err_run.data_error     = 1'b1;
		st3                    = st2;
		if (err) begin
			st3.active  = 1'b0;
			st3.partial = '0;
			st3.held    = '0;
		end

		// Pack the runs from entry 0 and mark the final one
		list = '0;
		if (st0.active && f_hi.complete) begin
			list.run[list.count] = f_hi.run;
			list.count           = list.count + 2'd1;
		end
		if (run_lo && f_lo.complete) begin
			list.run[list.count] = f_lo.run;
			list.count           = list.count + 2'd1;
		end
		if (err) begin
			list.run[list.count] = err_run;
			list.count           = list.count + 2'd1;
		end
		if (list.count != 2'd0) begin
			list.run[list.count - 2'd1].last_for_input = 1'b1;
		end
	end

	// Advance the decoder position with each byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= st3;
		end
	end

	always_comb begin
		push = list;
		if (!advance) begin
			push.count = 2'd0;
		end
	end

	ast_idle_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !state_q.active && !sof_s1) |-> (push.count == 2'd0))
		else $error("idle decoder produced runs");

	ast_three_needs_error: assert property (@(posedge clk) disable iff (!arst_n)
		(push.count == 2'd3) |-> push.run[2].data_error)
		else $error("three runs from one byte without buffer end");

	ast_idle_no_partial: assert property (@(posedge clk) disable iff (!arst_n)
		!state_q.active |-> (state_q.held == 2'd0))
		else $error("partial code kept while idle");

endmodule

`default_nettype wire

// File: rtl/spd_queue.sv
// Result queue: takes up to three runs a cycle from the decoder and hands
// them out one transaction at a time. Depends on spd_pkg and spd_if.
`default_nettype none

module spd_queue
	import spd_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  spd_push_t  push,
	output logic       space_ok,
	spd_out_if.source  run
);

	spd_run_t            mem [QDEPTH];
	logic [QPTR_W-1:0]   wp_q;
	logic [QPTR_W-1:0]   rp_q;
	logic [QCNT_W-1:0]   count_q;
	logic                pop;
	spd_run_t            head;

	assign space_ok = (count_q <= QCNT_W'(QDEPTH - MAX_RUNS));
	assign pop      = run.valid && run.ready;

	// Write the pushed runs in order
	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RUNS; i++) begin
			if (QCNT_W'(i) < QCNT_W'(push.count)) begin
				mem[wp_q + QPTR_W'(i)] <= push.run[i];
			end
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			wp_q    <= wp_q + QPTR_W'(push.count);
			rp_q    <= rp_q + QPTR_W'(pop);
			count_q <= count_q + QCNT_W'(push.count) - QCNT_W'(pop);
		end
	end

	assign head               = mem[rp_q];
	assign run.valid          = (count_q != '0);
	assign run.run_color      = head.run_color;
	assign run.run_length     = head.run_length;
	assign run.run_column     = head.run_column;
	assign run.run_row        = head.run_row;
	assign run.row_end        = head.row_end;
	assign run.field_done     = head.field_done;
	assign run.data_error     = head.data_error;
	assign run.last_for_input = head.last_for_input;

	ast_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("result queue over capacity");

	ast_push_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(push.count != 2'd0) |-> (QCNT_W'(QDEPTH) - count_q >= QCNT_W'(push.count)))
		else $error("push overruns result queue");

	ast_error_last: assert property (@(posedge clk) disable iff (!arst_n)
		(run.valid && run.data_error) |-> (run.last_for_input && run.run_length == 13'd0))
		else $error("error result malformed");

endmodule

`default_nettype wire
